/* src/multi_channel_valve_pulse_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// Valve pulse sequencer: assertion macros
// Short forms for the concurrent checks, clocked on clk and held off in rst.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_VALVE_PULSE_SEQUENCER_DEFINES_SVH
`define MULTI_CHANNEL_VALVE_PULSE_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define MVPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MVPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mvps_pkg.sv */
// ----------------------------------------------------------------------------
// Valve pulse sequencer package
// Shared widths, phase codes and the per-port record layout.
// ----------------------------------------------------------------------------
package mvps_pkg;

  localparam int PORTS_DEF     = 16;
  localparam int SENSORS_DEF   = 32;
  localparam int TICK_BITS_DEF = 32;

  localparam int PORT_W   = 4;
  localparam int SPAN_W   = 32;
  localparam int COUNT_W  = 8;
  localparam int SEL_W    = 6;
  localparam int NOW_W    = 32;
  localparam int SENS_W   = 32;
  localparam int PHASE_W  = 3;
  localparam int MAX_REPORT = 16;

  // sensor select value meaning "no sensor wait"
  localparam logic signed [SEL_W-1:0] SEL_NONE = -6'sd1;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE      = 3'd0,
    PH_CONFIG    = 3'd1,
    PH_GAP       = 3'd2,
    PH_RECOVER   = 3'd3,
    PH_SET       = 3'd4,
    PH_TRIGGER   = 3'd5,
    PH_HOLDSETUP = 3'd6
  } phase_t;

  // one port's record, deadline kept apart as its width is a parameter
  typedef struct packed {
    phase_t                   phase;
    logic                     level;
    logic                     target;
    logic [SPAN_W-1:0]        delay;
    logic [SPAN_W-1:0]        hold;
    logic [SPAN_W-1:0]        gap;
    logic [COUNT_W-1:0]       done_cnt;
    logic [COUNT_W-1:0]       goal;
    logic signed [SEL_W-1:0]  sel;
    logic                     sel_lvl;
  } rec_t;

endpackage

/* src/mvps_store.sv */
// ----------------------------------------------------------------------------
// Valve pulse sequencer record store
// Port records and deadlines in synchronous memories with registered reads.
// Per-entry valid flags make an unwritten port read as idle with valve off.
// ----------------------------------------------------------------------------
module mvps_store #(
  parameter int PORTS     = mvps_pkg::PORTS_DEF,
  parameter int TICK_BITS = mvps_pkg::TICK_BITS_DEF,
  parameter int AW        = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output mvps_pkg::rec_t        rd_rec,
  output logic [TICK_BITS-1:0]  rd_dl,
  output logic                  rd_valid,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  mvps_pkg::rec_t        wr_rec,
  input  logic [TICK_BITS-1:0]  wr_dl
);

  mvps_pkg::rec_t        rec_mem [PORTS];
  logic [TICK_BITS-1:0]  dl_mem  [PORTS];
  logic [PORTS-1:0]      vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[wr_addr] <= wr_rec;
      dl_mem[wr_addr]  <= wr_dl;
    end
    if (rd_en) begin
      rd_rec   <= rec_mem[rd_addr];
      rd_dl    <= dl_mem[rd_addr];
      rd_valid <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

endmodule

/* src/mvps_step.sv */
// ----------------------------------------------------------------------------
// Valve pulse sequencer phase step
// Advances one port record by at most one phase, or reloads it on an arm.
// ----------------------------------------------------------------------------
module mvps_step #(
  parameter int SENSORS   = mvps_pkg::SENSORS_DEF,
  parameter int TICK_BITS = mvps_pkg::TICK_BITS_DEF
) (
  input  logic                         arm,
  input  logic                         rec_valid,
  input  mvps_pkg::rec_t               rec_in,
  input  logic [TICK_BITS-1:0]         dl_in,
  input  mvps_pkg::rec_t               arm_rec,
  input  logic [mvps_pkg::NOW_W-1:0]   now_tick,
  input  logic [mvps_pkg::SENS_W-1:0]  sensor_bits,
  output mvps_pkg::rec_t               rec_out,
  output logic [TICK_BITS-1:0]         dl_out,
  output logic                         done
);

  mvps_pkg::rec_t                   cur;
  logic [mvps_pkg::SPAN_W-1:0]      span;
  logic [TICK_BITS-1:0]             now_t;
  logic [TICK_BITS-1:0]             sum;
  logic                             due;
  logic [mvps_pkg::COUNT_W-1:0]     cnt_inc;
  logic                             sens_ok;
  logic                             sens_val;

  always_comb begin
    cur = rec_in;
    if (!rec_valid) begin
      cur.phase  = mvps_pkg::PH_IDLE;
      cur.level  = 1'b0;
      cur.target = 1'b0;
    end
    case (cur.phase)
      mvps_pkg::PH_CONFIG:    span = cur.delay;
      mvps_pkg::PH_HOLDSETUP: span = cur.hold;
      default:                span = cur.gap;
    endcase
  end

  assign now_t   = TICK_BITS'(now_tick);
  assign sum     = now_t + TICK_BITS'(span);
  assign due     = dl_in <= now_t;
  assign cnt_inc = cur.done_cnt + mvps_pkg::COUNT_W'(1);

  // negative or out-of-range sensor reads as 0
  assign sens_ok  = !cur.sel[mvps_pkg::SEL_W-1] &&
                    (32'(cur.sel[mvps_pkg::SEL_W-2:0]) < 32'(SENSORS));
  assign sens_val = sens_ok && sensor_bits[cur.sel[mvps_pkg::SEL_W-2:0]];

  always_comb begin
    rec_out = cur;
    dl_out  = dl_in;
    done    = 1'b0;
    if (arm) begin
      rec_out          = arm_rec;
      rec_out.level    = cur.level;
      rec_out.done_cnt = '0;
      rec_out.phase    = mvps_pkg::PH_CONFIG;
    end else begin
      case (cur.phase)
        mvps_pkg::PH_RECOVER: begin
          if (due) begin
            rec_out.level    = ~cur.level;
            rec_out.done_cnt = cnt_inc;
            if (cnt_inc >= cur.goal) begin
              rec_out.phase = mvps_pkg::PH_IDLE;
              done          = 1'b1;
            end else begin
              dl_out        = sum;
              rec_out.phase = mvps_pkg::PH_GAP;
            end
          end
        end
        mvps_pkg::PH_GAP: begin
          if (due) rec_out.phase = mvps_pkg::PH_CONFIG;
        end
        mvps_pkg::PH_HOLDSETUP: begin
          if (cur.hold == '0) begin
            rec_out.phase = mvps_pkg::PH_IDLE;
            done          = 1'b1;
          end else begin
            dl_out        = sum;
            rec_out.phase = mvps_pkg::PH_RECOVER;
          end
        end
        mvps_pkg::PH_TRIGGER: begin
          if (sens_val == cur.sel_lvl) rec_out.phase = mvps_pkg::PH_HOLDSETUP;
        end
        mvps_pkg::PH_SET: begin
          if (due) begin
            rec_out.level = cur.target;
            rec_out.phase = (cur.sel == mvps_pkg::SEL_NONE) ? mvps_pkg::PH_HOLDSETUP
                                                            : mvps_pkg::PH_TRIGGER;
          end
        end
        mvps_pkg::PH_CONFIG: begin
          dl_out        = sum;
          rec_out.phase = mvps_pkg::PH_SET;
        end
        default: ;
      endcase
    end
  end

endmodule

/* src/multi_channel_valve_pulse_sequencer.sv */
// ----------------------------------------------------------------------------
// Multi-channel valve pulse sequencer
// Arm items load a port record; scan items walk the ports and step each one.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid / in_ready    op, port, arm settings, now_tick, bits
//  out      out  out_valid / out_ready  out_port, valve_level, phase, done_res,
//                                       last
//
// An arm steps one port; a scan steps ports 0 to min(PORTS,16)-1, one port per
// cycle unless a result waits, paced by the record memory's single read port.
// Reset clears the per-port valid flags at once; no clearing pass is needed.
// A result waiting in the output register holds the walk until it is taken;
// a new item is accepted once the previous one has queued its last result.
module multi_channel_valve_pulse_sequencer #(
  parameter int PORTS     = mvps_pkg::PORTS_DEF,
  parameter int SENSORS   = mvps_pkg::SENSORS_DEF,
  parameter int TICK_BITS = mvps_pkg::TICK_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [mvps_pkg::PORT_W-1:0]         port,
  input  logic                                target_level,
  input  logic [mvps_pkg::SPAN_W-1:0]         delay_ticks,
  input  logic [mvps_pkg::SPAN_W-1:0]         hold_ticks,
  input  logic [mvps_pkg::SPAN_W-1:0]         gap_ticks,
  input  logic [mvps_pkg::COUNT_W-1:0]        repeat_count,
  input  logic signed [mvps_pkg::SEL_W-1:0]   sensor_select,
  input  logic                                sensor_level,
  input  logic [mvps_pkg::NOW_W-1:0]          now_tick,
  input  logic [mvps_pkg::SENS_W-1:0]         sensor_bits,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mvps_pkg::PORT_W-1:0]         out_port,
  output logic                                valve_level,
  output logic [mvps_pkg::PHASE_W-1:0]        phase,
  output logic                                done_res,
  output logic                                last
);

  `include "multi_channel_valve_pulse_sequencer_defines.svh"

  localparam int AW    = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int NSCAN = (PORTS < mvps_pkg::MAX_REPORT) ? PORTS : mvps_pkg::MAX_REPORT;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_t;

  state_t state, state_next;

  logic                            accept, take, port_ok, fire, is_last;
  logic                            arm_q;
  mvps_pkg::rec_t                  arm_rec_q;
  logic [mvps_pkg::NOW_W-1:0]      now_q;
  logic [mvps_pkg::SENS_W-1:0]     bits_q;
  logic [AW-1:0]                   cur;

  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  mvps_pkg::rec_t                  rd_rec;
  logic [TICK_BITS-1:0]            rd_dl;
  logic                            rd_valid;
  mvps_pkg::rec_t                  step_rec;
  logic [TICK_BITS-1:0]            step_dl;
  logic                            step_done;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign port_ok  = 32'(port) < 32'(PORTS);
  // an arm of a missing port is dropped without a result
  assign take     = accept && (op || port_ok);
  assign fire     = (state == S_CALC) && (!out_valid || out_ready);
  assign is_last  = arm_q || (cur == AW'(NSCAN - 1));

  assign rd_en   = take || (fire && !is_last);
  assign rd_addr = take ? (op ? '0 : AW'(port)) : cur + AW'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (take) state_next = S_CALC;
      S_CALC: if (fire && is_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      arm_q              <= !op;
      now_q              <= now_tick;
      bits_q             <= sensor_bits;
      arm_rec_q.phase    <= mvps_pkg::PH_CONFIG;
      arm_rec_q.level    <= 1'b0;
      arm_rec_q.target   <= target_level;
      arm_rec_q.delay    <= delay_ticks;
      arm_rec_q.hold     <= hold_ticks;
      arm_rec_q.gap      <= gap_ticks;
      arm_rec_q.done_cnt <= '0;
      arm_rec_q.goal     <= repeat_count;
      arm_rec_q.sel      <= sensor_select;
      arm_rec_q.sel_lvl  <= sensor_level;
    end
    if (take) begin
      cur <= op ? '0 : AW'(port);
    end else if (fire && !is_last) begin
      cur <= cur + AW'(1);
    end
  end

  mvps_store #(
    .PORTS     (PORTS),
    .TICK_BITS (TICK_BITS),
    .AW        (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_rec   (rd_rec),
    .rd_dl    (rd_dl),
    .rd_valid (rd_valid),
    .wr_en    (fire),
    .wr_addr  (cur),
    .wr_rec   (step_rec),
    .wr_dl    (step_dl)
  );

  mvps_step #(
    .SENSORS   (SENSORS),
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .arm         (arm_q),
    .rec_valid   (rd_valid),
    .rec_in      (rd_rec),
    .dl_in       (rd_dl),
    .arm_rec     (arm_rec_q),
    .now_tick    (now_q),
    .sensor_bits (bits_q),
    .rec_out     (step_rec),
    .dl_out      (step_dl),
    .done        (step_done)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_port    <= mvps_pkg::PORT_W'(cur);
      valve_level <= step_rec.level;
      phase       <= step_rec.phase;
      done_res    <= step_done;
      last        <= is_last;
    end
  end

  `MVPS_ASSERT_NOW(a_done_idle, out_valid && done_res, phase == mvps_pkg::PH_IDLE, "done without idle phase")
  `MVPS_ASSERT_NOW(a_rw_clash, rd_en && fire, rd_addr != cur, "read and write of one record at once")
  `MVPS_ASSERT_NEXT(a_walk_on, fire && !is_last, state == S_CALC, "scan walk stopped early")

endmodule
